// ===== design/two_color_blink_code_sequencer_unit_assert.svh =====
// Assertion macros for the two-color blink-code sequencer.
`ifndef TWO_COLOR_BLINK_CODE_SEQUENCER_UNIT_ASSERT_SVH
`define TWO_COLOR_BLINK_CODE_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TCBS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tcbs: forbidden condition seen");
`define TCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcbs: expected result not seen in next cycle");
`else
`define TCBS_ASSERT_NEVER(label, clk, rst_n, expr)
`define TCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/tcbs_pkg.sv =====
// Types and constants shared by the two-color blink-code sequencer files.
package tcbs_pkg;

    localparam int NUM_CH     = 3;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int WORD_W     = 32;
    localparam int DARK_CNT_W = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLUE  = 2'd2;

    // First-code values that change channel modes instead of blinking.
    localparam logic [3:0] CODE_OFF  = 4'h0;
    localparam logic [3:0] CODE_AUTO = 4'hE;
    localparam logic [3:0] CODE_ON   = 4'hF;

    // Largest dark count: three times the widest off time.
    localparam logic [DARK_CNT_W-1:0] DARK_MAX = 10'd765;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_CLR_FIRST  = 3'd1,
        PH_CLR_SECOND = 3'd2,
        PH_SET_FIRST  = 3'd3,
        PH_SET_SECOND = 3'd4,
        PH_FINAL      = 3'd5
    } seq_phase_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_AUTO = 2'd1,
        MODE_ON   = 2'd2
    } mode_t;

    // Layout of a command word.
    typedef struct packed {
        logic [3:0] first_mask;
        logic [3:0] first_code;
        logic [3:0] second_mask;
        logic [3:0] second_count;
        logic [7:0] lit_time;
        logic [7:0] dark_time;
    } command_t;

endpackage

// ===== design/tcbs_item_in_if.sv =====
// Input channel: tick or command items.
interface tcbs_item_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] command_word;

    modport source (output valid, output req_type, output command_word, input ready);
    modport sink (input valid, input req_type, input command_word, output ready);
endinterface

// ===== design/tcbs_item_out_if.sv =====
// Output channel: one result item per input item.
interface tcbs_item_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic [7:0] pixel_blue;
    logic       pixel_sent;
    logic       cmd_accepted;
    logic       busy_res;

    modport source (output valid, output pixel_green, output pixel_red, output pixel_blue,
                    output pixel_sent, output cmd_accepted, output busy_res, input ready);
    modport sink (input valid, input pixel_green, input pixel_red, input pixel_blue,
                  input pixel_sent, input cmd_accepted, input busy_res, output ready);
endinterface

// ===== design/tcbs_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface tcbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [7:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/two_color_blink_code_sequencer_unit.sv =====
// Top level of the two-color blink-code sequencer.
// Each item is either a dwell tick or a 32-bit command and produces exactly one
// result item with the red, green and blue channel values, a sent flag, an
// accepted flag and the busy flag. An item is captured in an input register and
// processed by one pass of counter and mux logic into the result register, so
// one item per clock is sustained; the block stalls only when the result
// register is full and not taken. Level registers are written through the
// configuration channel, which is always ready; indexes beyond blue are ignored.
module two_color_blink_code_sequencer_unit (
    input logic clk,
    input logic rst_n,
    tcbs_item_in_if.sink    request,
    tcbs_item_out_if.source result,
    tcbs_cfg_if.sink        cfg
);

    `include "two_color_blink_code_sequencer_unit_assert.svh"

    // Configuration registers.
    logic [tcbs_pkg::LEVEL_W-1:0] level_reg [tcbs_pkg::NUM_CH];

    // Input register.
    logic                        in_valid_reg;
    logic                        in_req_reg;
    logic [tcbs_pkg::WORD_W-1:0] in_word_reg;
    tcbs_pkg::command_t          cmd;

    // Sequencer state.
    tcbs_pkg::seq_phase_t seq_phase_reg, seq_phase_next;
    logic                 indicating_reg, indicating_next;
    logic [3:0]           first_mask_reg, first_mask_next;
    logic [3:0]           first_count_reg, first_count_next;
    logic [3:0]           second_mask_reg, second_mask_next;
    logic [3:0]           second_count_reg, second_count_next;
    logic [7:0]           lit_time_reg, lit_time_next;
    logic [7:0]           dark_time_reg, dark_time_next;
    logic [7:0]           first_lit_reg, first_lit_next;
    logic [7:0]           second_lit_reg, second_lit_next;
    logic [tcbs_pkg::DARK_CNT_W-1:0] dark_counter_reg, dark_counter_next;
    tcbs_pkg::mode_t      channel_mode_reg [tcbs_pkg::NUM_CH];
    tcbs_pkg::mode_t      channel_mode_next [tcbs_pkg::NUM_CH];
    logic [tcbs_pkg::LEVEL_W-1:0] channel_value_reg [tcbs_pkg::NUM_CH];
    logic [tcbs_pkg::LEVEL_W-1:0] channel_value_next [tcbs_pkg::NUM_CH];

    // Paint control and flags.
    logic [tcbs_pkg::NUM_CH-1:0] set_mask;
    logic [tcbs_pkg::NUM_CH-1:0] clr_mask;
    logic                        sent;
    logic                        accepted;

    // Dark gap lengths: one, two and three off times.
    logic [tcbs_pkg::DARK_CNT_W-1:0] dark_x1;
    logic [tcbs_pkg::DARK_CNT_W-1:0] dark_x2;
    logic [tcbs_pkg::DARK_CNT_W-1:0] dark_x3;

    // Result register.
    logic                         out_valid_reg;
    logic [tcbs_pkg::LEVEL_W-1:0] out_green_reg;
    logic [tcbs_pkg::LEVEL_W-1:0] out_red_reg;
    logic [tcbs_pkg::LEVEL_W-1:0] out_blue_reg;
    logic                         out_sent_reg;
    logic                         out_accepted_reg;
    logic                         out_busy_reg;

    logic advance;

    // An item moves from the input register to the result register when there is room.
    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;
    assign cmd           = tcbs_pkg::command_t'(in_word_reg);

    assign dark_x1 = {2'b00, dark_time_reg};
    assign dark_x2 = {1'b0, dark_time_reg, 1'b0};
    assign dark_x3 = dark_x1 + dark_x2;

    // Level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < tcbs_pkg::NUM_CH; c++)
            begin
                level_reg[c] <= '1;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                tcbs_pkg::CFG_IDX_RED:   level_reg[0] <= cfg.wdata;
                tcbs_pkg::CFG_IDX_GREEN: level_reg[1] <= cfg.wdata;
                tcbs_pkg::CFG_IDX_BLUE:  level_reg[2] <= cfg.wdata;
                default:                 ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            in_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_req_reg  <= request.req_type;
            in_word_reg <= request.command_word;
        end
    end

    // Next state of the sequencer for the item in the input register.
    always_comb
    begin
        seq_phase_next    = seq_phase_reg;
        indicating_next   = indicating_reg;
        first_mask_next   = first_mask_reg;
        first_count_next  = first_count_reg;
        second_mask_next  = second_mask_reg;
        second_count_next = second_count_reg;
        lit_time_next     = lit_time_reg;
        dark_time_next    = dark_time_reg;
        first_lit_next    = first_lit_reg;
        second_lit_next   = second_lit_reg;
        dark_counter_next = dark_counter_reg;
        channel_mode_next = channel_mode_reg;
        set_mask          = '0;
        clr_mask          = '0;
        sent              = 1'b0;
        accepted          = 1'b0;

        if (advance)
        begin
            if (in_req_reg)
            begin
                // A command is taken only when no sequence runs.
                if (!indicating_reg)
                begin
                    accepted          = 1'b1;
                    first_mask_next   = cmd.first_mask;
                    first_count_next  = cmd.first_code;
                    second_mask_next  = cmd.second_mask;
                    second_count_next = cmd.second_count;
                    lit_time_next     = cmd.lit_time;
                    dark_time_next    = cmd.dark_time;
                    first_lit_next    = cmd.lit_time;
                    second_lit_next   = cmd.lit_time;
                    case (cmd.first_code)
                        tcbs_pkg::CODE_OFF:
                        begin
                            for (int c = 0; c < tcbs_pkg::NUM_CH; c++)
                            begin
                                if (cmd.first_mask[c])
                                begin
                                    channel_mode_next[c] = tcbs_pkg::MODE_OFF;
                                end
                            end
                            clr_mask = cmd.first_mask[tcbs_pkg::NUM_CH-1:0];
                            sent     = 1'b1;
                        end
                        tcbs_pkg::CODE_AUTO:
                        begin
                            for (int c = 0; c < tcbs_pkg::NUM_CH; c++)
                            begin
                                if (cmd.first_mask[c])
                                begin
                                    channel_mode_next[c] = tcbs_pkg::MODE_AUTO;
                                end
                            end
                        end
                        tcbs_pkg::CODE_ON:
                        begin
                            for (int c = 0; c < tcbs_pkg::NUM_CH; c++)
                            begin
                                if (cmd.first_mask[c])
                                begin
                                    channel_mode_next[c] = tcbs_pkg::MODE_ON;
                                end
                            end
                            set_mask = cmd.first_mask[tcbs_pkg::NUM_CH-1:0];
                            sent     = 1'b1;
                        end
                        default:
                        begin
                            // Blink sequence starts with the first color lit.
                            set_mask         = cmd.first_mask[tcbs_pkg::NUM_CH-1:0];
                            sent             = 1'b1;
                            first_count_next = cmd.first_code - 4'd1;
                            seq_phase_next   = tcbs_pkg::PH_CLR_FIRST;
                            indicating_next  = 1'b1;
                        end
                    endcase
                end
            end
            else if (indicating_reg)
            begin
                case (seq_phase_reg)
                    tcbs_pkg::PH_IDLE:
                    begin
                    end
                    tcbs_pkg::PH_CLR_FIRST:
                    begin
                        if (first_lit_reg <= 8'd1)
                        begin
                            first_lit_next = '0;
                            clr_mask       = first_mask_reg[tcbs_pkg::NUM_CH-1:0];
                            sent           = 1'b1;
                            seq_phase_next = tcbs_pkg::PH_SET_FIRST;
                            if (first_count_reg == 4'd0)
                            begin
                                if (second_mask_reg == 4'd0)
                                begin
                                    dark_counter_next = dark_x3;
                                end
                                else
                                begin
                                    dark_counter_next = dark_x2;
                                    seq_phase_next    = tcbs_pkg::PH_SET_SECOND;
                                end
                            end
                            else
                            begin
                                dark_counter_next = dark_x1;
                            end
                        end
                        else
                        begin
                            first_lit_next = first_lit_reg - 8'd1;
                        end
                    end
                    tcbs_pkg::PH_CLR_SECOND:
                    begin
                        if (second_lit_reg <= 8'd1)
                        begin
                            second_lit_next   = '0;
                            clr_mask          = second_mask_reg[tcbs_pkg::NUM_CH-1:0];
                            sent              = 1'b1;
                            seq_phase_next    = tcbs_pkg::PH_SET_SECOND;
                            dark_counter_next = (second_count_reg == 4'd0) ? dark_x3 : dark_x1;
                        end
                        else
                        begin
                            second_lit_next = second_lit_reg - 8'd1;
                        end
                    end
                    tcbs_pkg::PH_SET_FIRST, tcbs_pkg::PH_SET_SECOND:
                    begin
                        if (dark_counter_reg <= 10'd1)
                        begin
                            dark_counter_next = '0;
                            if ((first_count_reg != 4'd0)
                                && (seq_phase_reg == tcbs_pkg::PH_SET_FIRST))
                            begin
                                first_count_next = first_count_reg - 4'd1;
                                set_mask         = first_mask_reg[tcbs_pkg::NUM_CH-1:0];
                                sent             = 1'b1;
                                first_lit_next   = lit_time_reg;
                                seq_phase_next   = tcbs_pkg::PH_CLR_FIRST;
                            end
                            else if ((second_count_reg != 4'd0)
                                     && (seq_phase_reg == tcbs_pkg::PH_SET_SECOND))
                            begin
                                second_count_next = second_count_reg - 4'd1;
                                set_mask          = second_mask_reg[tcbs_pkg::NUM_CH-1:0];
                                sent              = 1'b1;
                                second_lit_next   = lit_time_reg;
                                seq_phase_next    = tcbs_pkg::PH_CLR_SECOND;
                            end
                            else
                            begin
                                seq_phase_next = tcbs_pkg::PH_FINAL;
                            end
                        end
                        else
                        begin
                            dark_counter_next = dark_counter_reg - 10'd1;
                        end
                    end
                    default:
                    begin
                        // Final phase: drop the command and end the sequence.
                        first_mask_next   = '0;
                        first_count_next  = '0;
                        second_mask_next  = '0;
                        second_count_next = '0;
                        lit_time_next     = '0;
                        dark_time_next    = '0;
                        dark_counter_next = '0;
                        seq_phase_next    = tcbs_pkg::PH_IDLE;
                        indicating_next   = 1'b0;
                    end
                endcase
            end
        end
    end

    // Channel painting: clear first, then set, using the updated modes.
    always_comb
    begin
        for (int c = 0; c < tcbs_pkg::NUM_CH; c++)
        begin
            channel_value_next[c] = channel_value_reg[c];
            if (clr_mask[c])
            begin
                channel_value_next[c] = (channel_mode_next[c] == tcbs_pkg::MODE_ON)
                                        ? level_reg[c] : '0;
            end
            if (set_mask[c])
            begin
                channel_value_next[c] = (channel_mode_next[c] == tcbs_pkg::MODE_OFF)
                                        ? '0 : level_reg[c];
            end
        end
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_phase_reg    <= tcbs_pkg::PH_IDLE;
            indicating_reg   <= 1'b0;
            first_mask_reg   <= '0;
            first_count_reg  <= '0;
            second_mask_reg  <= '0;
            second_count_reg <= '0;
            lit_time_reg     <= '0;
            dark_time_reg    <= '0;
            first_lit_reg    <= '0;
            second_lit_reg   <= '0;
            dark_counter_reg <= '0;
            for (int c = 0; c < tcbs_pkg::NUM_CH; c++)
            begin
                channel_mode_reg[c]  <= tcbs_pkg::MODE_AUTO;
                channel_value_reg[c] <= '0;
            end
        end
        else
        begin
            seq_phase_reg     <= seq_phase_next;
            indicating_reg    <= indicating_next;
            first_mask_reg    <= first_mask_next;
            first_count_reg   <= first_count_next;
            second_mask_reg   <= second_mask_next;
            second_count_reg  <= second_count_next;
            lit_time_reg      <= lit_time_next;
            dark_time_reg     <= dark_time_next;
            first_lit_reg     <= first_lit_next;
            second_lit_reg    <= second_lit_next;
            dark_counter_reg  <= dark_counter_next;
            channel_mode_reg  <= channel_mode_next;
            channel_value_reg <= channel_value_next;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_red_reg      <= channel_value_next[0];
            out_green_reg    <= channel_value_next[1];
            out_blue_reg     <= channel_value_next[2];
            out_sent_reg     <= sent;
            out_accepted_reg <= accepted;
            out_busy_reg     <= indicating_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pixel_green  = out_green_reg;
    assign result.pixel_red    = out_red_reg;
    assign result.pixel_blue   = out_blue_reg;
    assign result.pixel_sent   = out_sent_reg;
    assign result.cmd_accepted = out_accepted_reg;
    assign result.busy_res     = out_busy_reg;

    // The busy flag always agrees with the sequence phase.
    `TCBS_ASSERT_NEVER(a_busy_matches_phase, clk, rst_n, indicating_reg != (seq_phase_reg != tcbs_pkg::PH_IDLE))
    // The dark counter never exceeds three off times.
    `TCBS_ASSERT_NEVER(a_dark_in_range, clk, rst_n, dark_counter_reg > tcbs_pkg::DARK_MAX)
    // A command arriving during a sequence is refused.
    `TCBS_ASSERT_NEXT(a_busy_refuses, clk, rst_n, advance && in_req_reg && indicating_reg, !out_accepted_reg && !out_sent_reg)
    // A tick with no sequence running writes nothing to the strip.
    `TCBS_ASSERT_NEXT(a_idle_tick_quiet, clk, rst_n, advance && !in_req_reg && !indicating_reg, !out_sent_reg && !out_busy_reg)

endmodule
